// ===== hdl/crsf_pkg.sv =====
// Shared types, constants and the CRC8 step for the CRSF channel decoder.
// No dependencies; every other file except crsf_ram imports this package.
`default_nettype none
package crsf_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0] MAX_LEN      = 8'd62;
    localparam logic [5:0] FULL_PAYLOAD = 6'd22;
    localparam logic [10:0] RAW_LO      = 11'd172;
    localparam logic [10:0] RAW_HI      = 11'd1811;
    localparam logic [12:0] FULL_DIV    = 13'd1639;
    localparam logic [8:0]  FULL_LIMIT  = 9'd176;
    localparam logic [8:0]  SWITCH_BITS = 9'd10;
    localparam logic [7:0]  CRC_POLY    = 8'hD5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_CHAN = 2'd3;

    typedef enum logic [1:0] {PH_SYNC, PH_LEN, PH_BODY} t_phase;

    typedef enum logic [3:0] {
        B_IDLE, B_CHECK, B_A0, B_A1, B_A2, B_CAP, B_MUL, B_DIV, B_PUSH, B_STAT
    } t_bstate;

    typedef struct packed {
        logic [1:0] status;
        logic       run;
        logic       full_mode;
        logic [3:0] bits;
        logic [8:0] limit;
        logic [4:0] start;
    } t_job;

    typedef struct packed {
        logic        kind;
        logic [3:0]  idx;
        logic [15:0] value;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic run_done;
    } t_back_stat;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/crsf_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/crsf_jobq.sv =====
// Two-entry queue of decoded jobs between the byte parser and the channel engine.
// Depends on crsf_pkg.
`default_nettype none
module crsf_jobq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  crsf_pkg::t_job     i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output crsf_pkg::t_job     o_job
);
    import crsf_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/crsf_front.sv =====
// Byte parser: sync/length hunt, CRC8 check, frame store writes, job classification.
// Depends on crsf_pkg; drives the frame RAM write port and the job queue.
`default_nettype none
module crsf_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_acc,
    input  wire logic [7:0]              i_byte,
    input  wire logic [7:0]              i_sync_addr,
    input  wire logic [7:0]              i_full_code,
    input  wire logic [7:0]              i_subset_code,
    input  wire logic [5:0]              i_min_pay,
    input  crsf_pkg::t_back_stat         i_bstat,
    output logic                         o_lock,
    output logic                         o_we,
    output logic [crsf_pkg::ADDR_W-1:0]  o_waddr,
    output logic                         o_job_push,
    output crsf_pkg::t_job               o_job
);
    import crsf_pkg::*;

    t_phase     r_phase, n_phase;
    logic [5:0] r_len, n_len, r_cnt, n_cnt, cnt1, plen;
    logic [7:0] r_crc, n_crc, r_type, n_type, r_cfg, n_cfg, typ, cfg;
    logic       r_lock, frame_end, len_bad;
    logic [8:0] avail, resv;
    t_job       job_end;

    assign cnt1      = r_cnt + 6'd1;
    assign len_bad   = (i_byte < 8'd2) || (i_byte > MAX_LEN);
    assign frame_end = (cnt1 >= r_len);
    assign plen      = r_len - 6'd2;
    assign typ       = r_type;
    assign cfg       = (r_cnt == 6'd1) ? i_byte : r_cfg;
    assign avail     = (plen == 6'd0) ? 9'd0 : {plen - 6'd1, 3'b000};
    assign resv      = cfg[7] ? SWITCH_BITS : 9'd0;

    // classification of a finished frame
    always_comb begin
        job_end        = '0;
        job_end.status = ST_DATA;
        if (i_byte != r_crc) begin
            job_end.status = ST_ERR;
        end else if (typ == i_full_code) begin
            if (plen >= FULL_PAYLOAD) begin
                job_end.status    = ST_CHAN;
                job_end.run       = 1'b1;
                job_end.full_mode = 1'b1;
                job_end.bits      = 4'd11;
                job_end.limit     = FULL_LIMIT;
            end
        end else if (typ == i_subset_code) begin
            if (plen >= i_min_pay) begin
                job_end.status = ST_CHAN;
                job_end.run    = 1'b1;
                job_end.bits   = 4'd10 + {2'b00, cfg[6:5]};
                job_end.limit  = (avail > resv) ? avail - resv : 9'd0;
                job_end.start  = cfg[4:0];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (i_acc) begin
            unique case (r_phase)
                PH_LEN:  n_phase = len_bad ? PH_SYNC : PH_BODY;
                PH_BODY: n_phase = frame_end ? PH_SYNC : PH_BODY;
                default: n_phase = (i_byte == i_sync_addr) ? PH_LEN : PH_SYNC;
            endcase
        end
    end

    always_comb begin
        n_len      = r_len;
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_type     = r_type;
        n_cfg      = r_cfg;
        o_we       = 1'b0;
        o_job      = '0;
        o_job.status = ST_MORE;
        unique case (r_phase)
            PH_LEN: begin
                if (len_bad) o_job.status = ST_ERR;
                n_len = i_byte[5:0];
                n_cnt = 6'd0;
                n_crc = 8'd0;
            end
            PH_BODY: begin
                o_we  = 1'b1;
                n_cnt = cnt1;
                if (r_cnt == 6'd0) n_type = i_byte;
                if (r_cnt == 6'd1) n_cfg  = i_byte;
                if (frame_end) o_job = job_end;
                else           n_crc = crc_step(r_crc, i_byte);
            end
            default: begin
                if (i_byte != i_sync_addr) o_job.status = ST_ERR;
            end
        endcase
        o_we       = o_we && i_acc;
        o_job_push = i_acc;
    end

    assign o_waddr = r_cnt;
    assign o_lock  = r_lock;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_lock  <= 1'b0;
            r_len   <= 6'd0;
            r_cnt   <= 6'd0;
            r_crc   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            if (i_acc) begin
                r_len  <= n_len;
                r_cnt  <= n_cnt;
                r_crc  <= n_crc;
                r_type <= n_type;
                r_cfg  <= n_cfg;
            end
            // hold off new bytes while the engine still reads the frame store
            if (i_acc && o_job.run)    r_lock <= 1'b1;
            else if (i_bstat.run_done) r_lock <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/crsf_back.sv =====
// Channel engine: bit extraction from the frame store, scaling by a shared
// iterative divider, and the two-entry result queue. Depends on crsf_pkg.
`default_nettype none
module crsf_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_job_empty,
    input  crsf_pkg::t_job               i_job,
    output logic                         o_job_pop,
    input  wire logic [15:0]             i_scale,
    output logic [crsf_pkg::ADDR_W-1:0]  o_raddr,
    input  wire logic [7:0]              i_rdata,
    output crsf_pkg::t_back_stat         o_bstat,
    input  wire logic                    i_pop,
    output logic                         o_empty,
    output crsf_pkg::t_result            o_res
);
    import crsf_pkg::*;

    t_bstate     r_st, n_st;
    t_job        r_job;
    logic [8:0]  r_off;
    logic [4:0]  r_idx;
    logic [7:0]  r_d0, r_d1;
    logic [12:0] r_raw, div_c;
    logic [13:0] r_rem, rem_sh;
    logic [28:0] r_quo;
    logic [4:0]  r_step;
    logic [5:0]  a0;
    logic [23:0] win;
    logic [13:0] mask;
    logic [10:0] adj;
    logic        stop, q_wr, q_rd;
    t_result     q_in;
    t_result     r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_qc;

    assign a0   = (r_job.full_mode ? 6'd1 : 6'd2) + r_off[8:3];
    assign stop = ((r_off + {5'd0, r_job.bits}) > r_job.limit) || r_idx[4];
    assign win  = {i_rdata, r_d1, r_d0} >> r_off[2:0];
    assign mask = (14'd1 << r_job.bits) - 14'd1;
    assign div_c = r_job.full_mode ? FULL_DIV : mask[12:0];
    assign rem_sh = {r_rem[12:0], r_quo[28]};

    always_comb begin
        if (r_raw[10:0] < RAW_LO)      adj = 11'd0;
        else if (r_raw[10:0] > RAW_HI) adj = RAW_HI - RAW_LO;
        else                           adj = r_raw[10:0] - RAW_LO;
    end

    always_comb begin
        unique case (r_st)
            B_A0:    o_raddr = a0;
            B_A1:    o_raddr = a0 + 6'd1;
            default: o_raddr = a0 + 6'd2;
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE:  if (!i_job_empty) n_st = i_job.run ? B_CHECK : B_STAT;
            B_CHECK: n_st = stop ? B_STAT : B_A0;
            B_A0:    n_st = B_A1;
            B_A1:    n_st = B_A2;
            B_A2:    n_st = B_CAP;
            B_CAP:   n_st = B_MUL;
            B_MUL:   n_st = B_DIV;
            B_DIV:   if (r_step == 5'd28) n_st = B_PUSH;
            B_PUSH:  if (r_qc != 2'd2) n_st = B_CHECK;
            B_STAT:  if (r_qc != 2'd2) n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_st == B_IDLE) && !i_job_empty;
        q_in      = '0;
        q_wr      = 1'b0;
        o_bstat.run_done = 1'b0;
        unique case (r_st)
            B_PUSH: begin
                q_in.idx    = r_idx[3:0];
                q_in.value  = r_quo[15:0];
                q_in.status = ST_CHAN;
                q_wr        = (r_qc != 2'd2);
            end
            B_STAT: begin
                q_in.kind   = 1'b1;
                q_in.status = r_job.status;
                q_in.last   = 1'b1;
                q_wr        = (r_qc != 2'd2);
                o_bstat.run_done = q_wr && r_job.run;
            end
            default: ;
        endcase
    end

    assign q_rd    = i_pop && (r_qc != 2'd0);
    assign o_empty = (r_qc == 2'd0);
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_off <= 9'd0;
            r_idx <= i_job.start;
        end
        if (r_st == B_A1) r_d0 <= i_rdata;
        if (r_st == B_A2) r_d1 <= i_rdata;
        if (r_st == B_CAP) r_raw <= win[12:0] & mask[12:0];
        if (r_st == B_MUL) begin
            r_quo  <= 29'(({2'b00, r_job.full_mode ? adj : r_raw[10:0]}
                          | (r_job.full_mode ? 13'd0 : r_raw)) * i_scale);
            r_rem  <= 14'd0;
            r_step <= 5'd0;
        end
        if (r_st == B_DIV) begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, div_c}) begin
                r_rem <= rem_sh - {1'b0, div_c};
                r_quo <= {r_quo[27:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[27:0], 1'b0};
            end
            r_step <= r_step + 5'd1;
        end
        if (r_st == B_PUSH && q_wr) begin
            r_off <= r_off + {5'd0, r_job.bits};
            r_idx <= r_idx + 5'd1;
        end
        if (q_wr) r_q[r_wp] <= q_in;
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qc <= 2'd0;
        end else begin
            r_st <= n_st;
            if (q_wr) r_wp <= ~r_wp;
            if (q_rd) r_rp <= ~r_rp;
            r_qc <= r_qc + 2'(q_wr ? 1 : 0) - 2'(q_rd ? 1 : 0);
        end
    end

    a_qc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qc != 2'd3) else $error("result queue count out of range");
    a_stat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_STAT && q_wr) |=> (r_st == B_IDLE))
        else $error("status item did not end the job");
    a_push_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_PUSH) |-> !r_idx[4]) else $error("channel index beyond 15 emitted");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_PUSH && $past(r_st) == B_DIV) |-> ($past(r_step) == 5'd28))
        else $error("divider left early");
endmodule
`default_nettype wire

// ===== hdl/crsf_frame_channel_decoder.sv =====
// CRSF channel frame decoder: received bytes in, channel updates and statuses out.
// Each byte yields its results in order; any byte but a good channel frame end yields one status item, a
// good channel frame yields one item per updated channel and then the status item.
// At a channel frame end the engine handles each channel in turn with three frame store reads, one
// multiply and a 29-step shared divider, for up to sixteen channels; full stays high during that
// time. Configuration writes are always ready.
`default_nettype none
module crsf_frame_channel_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 o_item_kind,
    output logic [3:0]                           o_chan_index,
    output logic [15:0]                          o_chan_value,
    output logic [1:0]                           o_frame_status,
    output logic                                 o_last_item,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [crsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crsf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import crsf_pkg::*;

    logic [7:0]  r_sync, r_full, r_subset;
    logic [5:0]  r_minp;
    logic [15:0] r_scale;
    logic        acc, lock, we, jpush, jfull, jpop, jempty;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0]  rdata;
    t_job        job_in, job_out;
    t_back_stat  bstat;
    t_result     res;

    assign o_cfg_ready = 1'b1;
    assign full = jfull || lock;
    assign acc  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync   <= 8'd200;
            r_full   <= 8'd22;
            r_subset <= 8'd23;
            r_minp   <= 6'd2;
            r_scale  <= 16'd1000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SYNC:    r_sync   <= i_cfg_data[7:0];
                REG_FULL:    r_full   <= i_cfg_data[7:0];
                REG_SUBSET:  r_subset <= i_cfg_data[7:0];
                REG_MIN_PAY: r_minp   <= i_cfg_data[5:0];
                REG_SCALE:   r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    crsf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(acc), .i_byte(i_rx_byte),
        .i_sync_addr(r_sync), .i_full_code(r_full), .i_subset_code(r_subset),
        .i_min_pay(r_minp), .i_bstat(bstat), .o_lock(lock), .o_we(we),
        .o_waddr(waddr), .o_job_push(jpush), .o_job(job_in)
    );

    crsf_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(i_rx_byte),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    crsf_jobq u_jobq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(jpush), .i_job(job_in), .o_full(jfull),
        .i_pop(jpop), .o_empty(jempty), .o_job(job_out)
    );

    crsf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_empty(jempty), .i_job(job_out),
        .o_job_pop(jpop), .i_scale(r_scale), .o_raddr(raddr), .i_rdata(rdata),
        .o_bstat(bstat), .i_pop(pop), .o_empty(empty), .o_res(res)
    );

    assign o_item_kind    = res.kind;
    assign o_chan_index   = res.idx;
    assign o_chan_value   = res.value;
    assign o_frame_status = res.status;
    assign o_last_item    = res.last;
endmodule
`default_nettype wire

// ===== sim/tb_crsf_frame_channel_decoder.sv =====
// Self-checking testbench for crsf_frame_channel_decoder: builds CRSF frames from random
// bytes, predicts the channel and status items with a scoreboard class. Needs crsf_pkg.
`timescale 1ns / 1ps
module tb_crsf_frame_channel_decoder;
    import crsf_pkg::*;

    localparam logic KIND_CHAN = 1'b0;
    localparam logic KIND_STAT = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   HOLD_CYCLES = 3000;

    class frame_scoreboard;
        t_phase      phase;
        logic [5:0]  flen, cnt;
        logic [7:0]  crc;
        logic [7:0]  store [FRAME_BYTES];
        logic [7:0]  sync_addr, full_code, subset_code;
        logic [5:0]  min_pay;
        logic [15:0] scale;
        t_result     pending_items [$];

        function new();
            phase = PH_SYNC; flen = 0; cnt = 0; crc = 0;
            sync_addr = 8'd200; full_code = 8'd22; subset_code = 8'd23;
            min_pay = 6'd2; scale = 16'd1000;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
            case (idx)
                REG_SYNC:    sync_addr = d[7:0];
                REG_FULL:    full_code = d[7:0];
                REG_SUBSET:  subset_code = d[7:0];
                REG_MIN_PAY: min_pay = d[5:0];
                REG_SCALE:   scale = d;
                default: ;
            endcase
        endfunction

        function logic [7:0] crc8(logic [7:0] c, logic [7:0] b);
            logic [7:0] v;
            v = c ^ b;
            for (int i = 0; i < 8; i++) v = v[7] ? ((v << 1) ^ 8'hD5) : (v << 1);
            return v;
        endfunction

        // LSB-first bit field starting at byte base
        function int unsigned field(int base, int off, int n);
            int unsigned raw;
            int p;
            raw = 0;
            for (int i = 0; i < n; i++) begin
                p = off + i;
                if (store[base + (p >> 3)][p & 7]) raw |= 1 << i;
            end
            return raw;
        endfunction

        function void add_chan(int idx, longint unsigned v);
            t_result r;
            r.kind = KIND_CHAN; r.idx = idx[3:0]; r.value = v[15:0];
            r.status = ST_CHAN; r.last = 1'b0;
            pending_items.push_back(r);
        endfunction

        function logic [1:0] decode_frame();
            int plen, bits, avail, resv, count, idx;
            int unsigned raw;
            logic [7:0] cfg;
            plen = int'(flen) - 2;
            if (store[0] == full_code) begin
                if (plen < FULL_PAYLOAD) return ST_DATA;
                for (int ch = 0; ch < 16; ch++) begin
                    raw = field(1, ch * 11, 11);
                    if (raw < RAW_LO) raw = RAW_LO;
                    if (raw > RAW_HI) raw = RAW_HI;
                    add_chan(ch, longint'(raw - RAW_LO) * scale / 1639);
                end
                return ST_CHAN;
            end
            if (store[0] == subset_code) begin
                if (plen < min_pay) return ST_DATA;
                cfg = store[1];
                bits = 10 + cfg[6:5];
                avail = (plen - 1) * 8;
                resv = cfg[7] ? 10 : 0;
                count = avail > resv ? (avail - resv) / bits : 0;
                for (int ch = 0; ch < count; ch++) begin
                    idx = cfg[4:0] + ch;
                    if (idx >= 16) continue;
                    raw = field(2, ch * bits, bits);
                    add_chan(idx, longint'(raw) * scale / ((1 << bits) - 1));
                end
                return ST_CHAN;
            end
            return ST_DATA;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [1:0] st;
            t_result r;
            st = ST_MORE;
            case (phase)
                PH_LEN: begin
                    if (b < 2 || b > MAX_LEN) begin
                        phase = PH_SYNC; st = ST_ERR;
                    end else begin
                        flen = b[5:0]; cnt = 0; crc = 0; phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    store[cnt] = b;
                    cnt = cnt + 1;
                    if (cnt >= flen) begin
                        phase = PH_SYNC;
                        st = (b != crc) ? ST_ERR : decode_frame();
                    end else begin
                        crc = crc8(crc, b);
                    end
                end
                default: begin
                    if (b == sync_addr) phase = PH_LEN;
                    else begin
                        phase = PH_SYNC; st = ST_ERR;
                    end
                end
            endcase
            r.kind = KIND_STAT; r.idx = 0; r.value = 0; r.status = st; r.last = 1'b1;
            pending_items.push_back(r);
        endfunction

        // empty string when the item matches the oldest prediction
        function string check_item(t_result got);
            t_result e;
            string msg;
            if (pending_items.size() == 0)
                return $sformatf("unexpected item kind=%0d idx=%0d val=%0d st=%0d",
                                 got.kind, got.idx, got.value, got.status);
            e = pending_items.pop_front();
            msg = "";
            if (got.kind != e.kind)
                msg = {msg, $sformatf(" kind %0d/%0d", got.kind, e.kind)};
            if (got.idx != e.idx)
                msg = {msg, $sformatf(" idx %0d/%0d", got.idx, e.idx)};
            if (got.value != e.value)
                msg = {msg, $sformatf(" value %0d/%0d", got.value, e.value)};
            if (got.status != e.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, e.status)};
            if (got.last != e.last)
                msg = {msg, $sformatf(" last %0d/%0d", got.last, e.last)};
            return msg == "" ? "" : {"mismatch got/exp:", msg};
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  pop = 1'b0;
    logic [7:0]            i_rx_byte = 8'h00;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  full, empty, o_cfg_ready;
    logic                  o_item_kind, o_last_item;
    logic [3:0]            o_chan_index;
    logic [15:0]           o_chan_value;
    logic [1:0]            o_frame_status;

    frame_scoreboard sb = new();
    int  errors = 0;
    int  cycles = 0;
    int  bytes_sent = 0;
    bit  hold_req = 1'b0;

    crsf_frame_channel_decoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_rx_byte(i_rx_byte),
        .empty(empty), .pop(pop), .o_item_kind(o_item_kind), .o_chan_index(o_chan_index),
        .o_chan_value(o_chan_value), .o_frame_status(o_frame_status),
        .o_last_item(o_last_item), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR %s", $time, msg);
        errors++;
    endtask

    // result side: random pop gaps, one long hold-off on request
    initial begin : result_drain
        t_result got;
        string msg;
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk) pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                @(negedge i_clk) pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.kind = o_item_kind; got.idx = o_chan_index; got.value = o_chan_value;
            got.status = o_frame_status; got.last = o_last_item;
            msg = sb.check_item(got);
            if (msg != "") report_mismatch(msg);
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            @(negedge i_clk) push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // sync, length, type, payload, CRC over type and payload
    task automatic send_frame(logic [7:0] ftype, logic [7:0] pay [$], bit bad_crc);
        logic [7:0] c;
        c = sb.crc8(8'h00, ftype);
        foreach (pay[i]) c = sb.crc8(c, pay[i]);
        if (bad_crc) c = c ^ (8'h01 << $urandom_range(0, 7));
        send_byte(sb.sync_addr);
        send_byte(8'(pay.size() + 2));
        send_byte(ftype);
        foreach (pay[i]) send_byte(pay[i]);
        send_byte(c);
    endtask

    function automatic void fill_payload(ref logic [7:0] pay [$], input int n);
        pay = {};
        repeat (n) pay.push_back(8'($urandom));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk) push <= 1'b0;
        while (sb.pending_items.size() != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic load_config(logic [7:0] sy, logic [7:0] fc, logic [7:0] sc,
                               logic [5:0] mp, logic [15:0] scl);
        write_reg(REG_SYNC, sy);
        write_reg(REG_FULL, fc);
        write_reg(REG_SUBSET, sc);
        write_reg(REG_MIN_PAY, mp);
        write_reg(REG_SCALE, scl);
    endtask

    task automatic random_traffic(int n_bytes);
        logic [7:0] pay [$];
        int stop, r;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                fill_payload(pay, $urandom_range(0, 3) == 0 ? $urandom_range(22, 60) : 22);
                send_frame(sb.full_code, pay, 1'b0);
            end else if (r < 55) begin
                fill_payload(pay, $urandom_range(1, 60));
                send_frame(sb.subset_code, pay, 1'b0);
            end else if (r < 63) begin
                fill_payload(pay, $urandom_range(0, 12));
                send_frame(8'($urandom), pay, 1'b0);
            end else if (r < 75) begin
                fill_payload(pay, $urandom_range(0, 30));
                send_frame($urandom_range(0, 1) ? sb.full_code : sb.subset_code, pay, 1'b1);
            end else if (r < 85) begin
                send_byte(sb.sync_addr);
                send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(63, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] pay [$];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed: bad sync, bad lengths, extremes of channel data
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(sb.sync_addr); send_byte(8'd1);
        send_byte(sb.sync_addr); send_byte(8'd63);
        pay = {}; repeat (22) pay.push_back(8'h00);
        send_frame(sb.full_code, pay, 1'b0);
        pay = {}; repeat (22) pay.push_back(8'hFF);
        send_frame(sb.full_code, pay, 1'b0);
        // short full payload, CRC error
        fill_payload(pay, 21); send_frame(sb.full_code, pay, 1'b0);
        fill_payload(pay, 22); send_frame(sb.full_code, pay, 1'b1);
        // subset: reserved bits exceed data, index past 15, high resolution, min payload
        pay = {8'h80, 8'hFF}; send_frame(sb.subset_code, pay, 1'b0);
        pay = {8'h0E, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_frame(sb.subset_code, pay, 1'b0);
        pay = {8'h7F, 8'hAA, 8'h55}; send_frame(sb.subset_code, pay, 1'b0);
        pay = {8'h60}; repeat (59) pay.push_back(8'hFF);
        send_frame(sb.subset_code, pay, 1'b0);
        pay = {8'h00}; send_frame(sb.subset_code, pay, 1'b0);
        // other type, shortest legal frame
        pay = {}; send_frame(8'h42, pay, 1'b0);
        random_traffic(15);
        settle();

        load_config(8'($urandom), 8'd22, 8'd23, 6'($urandom_range(1, 60)), 16'($urandom));
        hold_req = 1'b1;
        random_traffic(20);
        settle();

        // both type codes equal: full rule wins
        load_config(8'h00, 8'hFF, 8'hFF, 6'd60, 16'hFFFF);
        random_traffic(10);
        settle();

        load_config(8'hFF, 8'h00, 8'h01, 6'd1, 16'd1);
        pay = {8'h1F, 8'hFF, 8'hFF}; send_frame(sb.subset_code, pay, 1'b0);
        random_traffic(15);
        settle();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/crsf_pkg.sv
hdl/crsf_ram.sv
hdl/crsf_jobq.sv
hdl/crsf_front.sv
hdl/crsf_back.sv
hdl/crsf_frame_channel_decoder.sv
sim/tb_crsf_frame_channel_decoder.sv
